// ===== rtl/core/sha256_pkg.sv =====
package sha256_pkg;

  localparam int unsigned RoundCount = 64;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenOffset = 56;
  localparam int unsigned QueueDepth = 2;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  // One queued operation: a plain byte or a finish request.
  typedef struct packed {
    logic       is_finish;
    logic [7:0] data;
  } op_t;

  typedef logic [7:0][31:0] hash_t;

  localparam hash_t InitHash = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic logic [31:0] round_k(input logic [5:0] t);
    logic [31:0] k;
    unique case (t)
      6'd0: k = 32'h428a2f98;  6'd1: k = 32'h71374491;  6'd2: k = 32'hb5c0fbcf;
      6'd3: k = 32'he9b5dba5;  6'd4: k = 32'h3956c25b;  6'd5: k = 32'h59f111f1;
      6'd6: k = 32'h923f82a4;  6'd7: k = 32'hab1c5ed5;  6'd8: k = 32'hd807aa98;
      6'd9: k = 32'h12835b01;  6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
      6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
      6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
      6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
      6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
      6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
      6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
      6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
      6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
      default: k = 32'hc67178f2;
    endcase
    return k;
  endfunction

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

endpackage

// ===== rtl/core/sha256_if.sv =====
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] msg_byte;
  modport source (output valid, output req_type, output msg_byte, input ready);
  modport sink (input valid, input req_type, input msg_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ===== rtl/core/sha256_byte_stream_hasher.sv =====
// Channel  Direction  Payload
// in       sink       req_type, msg_byte
// out      source     digest_word, word_index, last_word
//
// A message byte is written into the block buffer; a byte that completes a block
// then starts the 64 rounds and the hash update.
// A finish pads one byte a cycle through the rest of the block, compresses one or
// two blocks, then offers eight digest words, one per cycle while out_ch.ready is high.
// A two-entry queue accepts up to two operations while the round loop or the output stalls.
// Reset is synchronous and restores the initial hash values.
module sha256_byte_stream_hasher (
  input logic          clk,
  input logic          rst_n,
  sha256_in_if.sink    in_ch,
  sha256_out_if.source out_ch
);

  sha256_pkg::op_t op;
  logic            op_valid, op_pop;

  sha256_front u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
    .op(op), .op_valid(op_valid), .op_pop(op_pop)
  );

  sha256_back u_back (
    .clk(clk), .rst_n(rst_n), .op(op), .op_valid(op_valid),
    .op_pop(op_pop), .out_ch(out_ch)
  );

endmodule

// ===== rtl/core/sha256_front.sv =====
module sha256_front (
  input  logic                clk,
  input  logic                rst_n,
  sha256_in_if.sink           in_ch,
  output sha256_pkg::op_t     op,
  output logic                op_valid,
  input  logic                op_pop
);

  sha256_pkg::op_t q_r [sha256_pkg::QueueDepth];
  logic            wr_ptr_r, rd_ptr_r;
  logic [1:0]      cnt_r;
  logic            push;

  assign in_ch.ready = (cnt_r != 2'(sha256_pkg::QueueDepth));
  assign push = in_ch.valid && in_ch.ready;
  assign op_valid = (cnt_r != 2'd0);
  assign op = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{is_finish: (in_ch.req_type == sha256_pkg::REQ_FINISH),
                         data: in_ch.msg_byte};
    end
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (op_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push) - 2'(op_pop);
    end
  end

endmodule

// ===== rtl/core/sha256_back.sv =====
module sha256_back (
  input  logic            clk,
  input  logic            rst_n,
  input  sha256_pkg::op_t op,
  input  logic            op_valid,
  output logic            op_pop,
  sha256_out_if.source    out_ch
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_PAD    = 3'd1;
  localparam logic [2:0] ST_ROUND  = 3'd2;
  localparam logic [2:0] ST_UPDATE = 3'd3;
  localparam logic [2:0] ST_EMIT   = 3'd4;

  logic [2:0]           state_r, state_nxt;
  logic [31:0]          blk_r [16];
  logic [5:0]           fill_r;
  logic [63:0]          bits_r;
  sha256_pkg::hash_t    h_r;
  logic [31:0]          w_r [16];
  logic [31:0]          va_r, vb_r, vc_r, vd_r, ve_r, vf_r, vg_r, vh_r;
  logic [5:0]           t_r;
  logic                 fin_r;
  logic                 final_blk_r;
  logic [2:0]           idx_r;

  logic [31:0] w_cur, w2, w15, s0, s1, t1, t2;
  logic        pad_wr;
  logic [7:0]  pad_byte;

  always_comb begin
    w2 = w_r[4'(t_r - 6'd2)];
    w15 = w_r[4'(t_r - 6'd15)];
    s1 = sha256_pkg::rotr(w2, 17) ^ sha256_pkg::rotr(w2, 19) ^ (w2 >> 10);
    s0 = sha256_pkg::rotr(w15, 7) ^ sha256_pkg::rotr(w15, 18) ^ (w15 >> 3);
    if (t_r < 6'd16) begin
      w_cur = blk_r[t_r[3:0]];
    end else begin
      w_cur = s1 + w_r[4'(t_r - 6'd7)] + s0 + w_r[t_r[3:0]];
    end
    t1 = vh_r + (sha256_pkg::rotr(ve_r, 6) ^ sha256_pkg::rotr(ve_r, 11) ^
                 sha256_pkg::rotr(ve_r, 25)) + ((ve_r & vf_r) ^ (~ve_r & vg_r)) +
         sha256_pkg::round_k(t_r) + w_cur;
    t2 = (sha256_pkg::rotr(va_r, 2) ^ sha256_pkg::rotr(va_r, 13) ^
          sha256_pkg::rotr(va_r, 22)) + ((va_r & vb_r) ^ (va_r & vc_r) ^ (vb_r & vc_r));
  end

  // Padding writes one byte a cycle: the marker, zeros, then, in the final block, the length.
  always_comb begin
    pad_wr = 1'b0;
    pad_byte = 8'h00;
    if (state_r == ST_PAD) begin
      pad_wr = 1'b1;
      if (!fin_r) pad_byte = sha256_pkg::PadByte;
      else if (final_blk_r && fill_r >= 6'(sha256_pkg::LenOffset))
        pad_byte = bits_r[8'(7 - fill_r[2:0]) * 8 +: 8];
    end
  end

  always_comb begin
    state_nxt = state_r;
    op_pop = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (op_valid) begin
          op_pop = 1'b1;
          if (op.is_finish) state_nxt = ST_PAD;
          else if (fill_r == 6'd63) state_nxt = ST_ROUND;
        end
      end
      ST_PAD: begin
        if (fill_r == 6'd63) state_nxt = ST_ROUND;
      end
      ST_ROUND: begin
        if (t_r == 6'd63) state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (!fin_r) state_nxt = ST_IDLE;
        else if (final_blk_r) state_nxt = ST_EMIT;
        else state_nxt = ST_PAD;
      end
      ST_EMIT: begin
        if (out_ch.ready && idx_r == 3'd7) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign out_ch.valid = (state_r == ST_EMIT);
  assign out_ch.digest_word = h_r[idx_r];
  assign out_ch.word_index = idx_r;
  assign out_ch.last_word = (idx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && op_valid && !op.is_finish)
      blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= op.data;
    else if (pad_wr) blk_r[fill_r[5:2]][{~fill_r[1:0], 3'b000} +: 8] <= pad_byte;
    if (state_r == ST_ROUND) w_r[t_r[3:0]] <= w_cur;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r <= 6'd0;
      bits_r <= 64'd0;
      h_r <= sha256_pkg::InitHash;
      t_r <= 6'd0;
      fin_r <= 1'b0;
      final_blk_r <= 1'b0;
      idx_r <= 3'd0;
    end else begin
      state_r <= state_nxt;
      unique case (state_r)
        ST_IDLE: begin
          if (op_valid) begin
            if (op.is_finish) begin
              final_blk_r <= (fill_r < 6'(sha256_pkg::LenOffset));
            end else begin
              fill_r <= fill_r + 6'd1;
              bits_r <= bits_r + 64'd8;
            end
          end
        end
        ST_PAD: begin
          fin_r <= 1'b1;
          fill_r <= fill_r + 6'd1;
        end
        ST_ROUND: begin
          t_r <= t_r + 6'd1;
          va_r <= t1 + t2; vb_r <= va_r; vc_r <= vb_r; vd_r <= vc_r;
          ve_r <= vd_r + t1; vf_r <= ve_r; vg_r <= vf_r; vh_r <= vg_r;
        end
        ST_UPDATE: begin
          h_r[0] <= h_r[0] + va_r; h_r[1] <= h_r[1] + vb_r;
          h_r[2] <= h_r[2] + vc_r; h_r[3] <= h_r[3] + vd_r;
          h_r[4] <= h_r[4] + ve_r; h_r[5] <= h_r[5] + vf_r;
          h_r[6] <= h_r[6] + vg_r; h_r[7] <= h_r[7] + vh_r;
          final_blk_r <= 1'b1;
        end
        ST_EMIT: begin
          if (out_ch.ready) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              h_r <= sha256_pkg::InitHash;
              bits_r <= 64'd0;
              fin_r <= 1'b0;
              final_blk_r <= 1'b0;
            end
          end
        end
        default: ;
      endcase
      if (state_nxt == ST_ROUND && state_r != ST_ROUND) begin
        va_r <= h_r[0]; vb_r <= h_r[1]; vc_r <= h_r[2]; vd_r <= h_r[3];
        ve_r <= h_r[4]; vf_r <= h_r[5]; vg_r <= h_r[6]; vh_r <= h_r[7];
        t_r <= 6'd0;
      end
      if (state_r == ST_IDLE && state_nxt == ST_ROUND) fill_r <= 6'd0;
      if (state_r == ST_PAD && state_nxt == ST_ROUND) fill_r <= 6'd0;
    end
  end

endmodule

// ===== tb/sha256_byte_stream_hasher_test.sv =====
module sha256_byte_stream_hasher_test;

  localparam int unsigned IdleLimit = 20000;
  localparam int unsigned DrainCycles = 300;

  typedef struct {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } digest_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha256_in_if in_ch ();
  sha256_out_if out_ch ();

  sha256_byte_stream_hasher dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #6 clk = ~clk;

  sha256_pkg::op_t pending_ops[$];
  digest_word_t expected_words[$];
  int unsigned mismatch_count = 0;
  int unsigned idle_cycles = 0;
  int unsigned drive_gap = 0;
  int unsigned sink_gap = 0;
  int unsigned hold_off = 0;
  bit hold_off_armed = 1'b0;
  bit stimulus_done = 1'b0;

  logic [31:0] hash_state[8];
  logic [7:0]  block_buf[64];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic int unsigned pick_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  task automatic restart_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = sha256_pkg::InitHash[i];
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    block_fill = 0;
    msg_bits = 64'd0;
  endtask

  task automatic compress_buf();
    logic [31:0] w[64];
    logic [31:0] v[8];
    logic [31:0] t1;
    logic [31:0] t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block_buf[4*t], block_buf[4*t+1], block_buf[4*t+2], block_buf[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = (ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10)) + w[t-7] +
             (ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3)) + w[t-16];
    for (int j = 0; j < 8; j++) v[j] = hash_state[j];
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) +
           ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::round_k(t[5:0]) + w[t];
      t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) +
           ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      for (int j = 7; j > 0; j--) v[j] = v[j-1];
      v[4] = v[4] + t1;
      v[0] = t1 + t2;
    end
    for (int j = 0; j < 8; j++) hash_state[j] = hash_state[j] + v[j];
  endtask

  task automatic predict_op(sha256_pkg::op_t op);
    digest_word_t dw;
    if (op.is_finish == sha256_pkg::REQ_BYTE) begin
      block_buf[block_fill] = op.data;
      msg_bits = msg_bits + 64'd8;
      block_fill++;
      if (block_fill == sha256_pkg::BlockBytes) begin
        compress_buf();
        block_fill = 0;
      end
    end else begin
      block_buf[block_fill] = sha256_pkg::PadByte;
      block_fill++;
      if (block_fill > sha256_pkg::LenOffset) begin
        while (block_fill < sha256_pkg::BlockBytes) block_buf[block_fill++] = 8'h00;
        compress_buf();
        block_fill = 0;
      end
      while (block_fill < sha256_pkg::LenOffset) block_buf[block_fill++] = 8'h00;
      for (int i = 0; i < 8; i++)
        block_buf[sha256_pkg::LenOffset + i] = msg_bits[63 - 8*i -: 8];
      compress_buf();
      for (int i = 0; i < 8; i++) begin
        dw.digest_word = hash_state[i];
        dw.word_index = i[2:0];
        dw.last_word = (i == 7);
        expected_words.push_back(dw);
      end
      restart_hash();
    end
  endtask

  task automatic add_byte(logic [7:0] b);
    sha256_pkg::op_t op;
    op.is_finish = sha256_pkg::REQ_BYTE;
    op.data = b;
    pending_ops.push_back(op);
  endtask

  task automatic add_finish(logic [7:0] junk);
    sha256_pkg::op_t op;
    op.is_finish = sha256_pkg::REQ_FINISH;
    op.data = junk;
    pending_ops.push_back(op);
  endtask

  task automatic add_message(int unsigned len);
    for (int unsigned i = 0; i < len; i++) add_byte($urandom_range(0, 255));
    add_finish($urandom_range(0, 255));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.req_type <= sha256_pkg::REQ_BYTE;
      in_ch.msg_byte <= 8'h00;
      drive_gap <= 0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (in_ch.valid) predict_op('{is_finish: in_ch.req_type, data: in_ch.msg_byte});
      if (drive_gap != 0 || pending_ops.size() == 0) begin
        in_ch.valid <= 1'b0;
        if (drive_gap != 0) drive_gap <= drive_gap - 1;
      end else begin
        sha256_pkg::op_t op;
        op = pending_ops.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.req_type <= op.is_finish;
        in_ch.msg_byte <= op.data;
        drive_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_gap <= 0;
      hold_off <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Unexpected digest transaction: word %h index %0d last %b",
                     out_ch.digest_word, out_ch.word_index, out_ch.last_word);
        end else begin
          digest_word_t exp_w;
          exp_w = expected_words.pop_front();
          if (exp_w.digest_word !== out_ch.digest_word ||
              exp_w.word_index !== out_ch.word_index ||
              exp_w.last_word !== out_ch.last_word) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("Digest mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                       exp_w.digest_word, exp_w.word_index, exp_w.last_word,
                       out_ch.digest_word, out_ch.word_index, out_ch.last_word);
          end
        end
      end
      if (hold_off_armed && hold_off == 0 && expected_words.size() != 0) begin
        hold_off_armed <= 1'b0;
        hold_off <= 2000;
        out_ch.ready <= 1'b0;
      end else if (hold_off != 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 1'b0;
      end else if (sink_gap != 0) begin
        sink_gap <= sink_gap - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        sink_gap <= pick_gap();
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      idle_cycles <= 0;
    else if (!stimulus_done || expected_words.size() != 0) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
        $display("Verification failed");
        $finish;
      end
    end
  end

  initial begin
    restart_hash();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    add_finish(8'hff);
    add_byte(8'h61); add_byte(8'h62); add_byte(8'h63); add_finish(8'h00);
    add_byte(8'h00); add_byte(8'hff); add_finish(8'hff);
    add_byte(8'hff); add_finish(8'h00);
    add_finish(8'h55);
    wait (pending_ops.size() == 0);
    add_message(55);
    add_message(56);
    add_message(63);
    add_message(64);
    hold_off_armed = 1'b1;
    add_message(3); add_message(0); add_message(5);
    while (pending_ops.size() != 0) @(posedge clk);

    for (int n = 0; n < 12; n++) begin
      add_message($urandom_range(0, 12));
      while (pending_ops.size() > 8) @(posedge clk);
    end
    while (pending_ops.size() != 0 || in_ch.valid) @(posedge clk);
    stimulus_done = 1'b1;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (mismatch_count == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/sha256_pkg.sv
rtl/core/sha256_if.sv
rtl/core/sha256_front.sv
rtl/core/sha256_back.sv
rtl/core/sha256_byte_stream_hasher.sv
tb/sha256_byte_stream_hasher_test.sv
